[sv/lplg_pkg.sv]
`default_nettype none

package lplg_pkg;

  localparam int DataWidth   = 16;
  localparam int AccWidth    = 48;
  localparam int MaxExponent = 8;
  localparam int FracBits    = 12;
  localparam int ExpWidth    = 4;
  localparam int QueueDepth  = 2;

  // magnitudes never exceed the largest positive accumulator value
  localparam int MagWidth  = AccWidth - 1;
  localparam int ProdWidth = MagWidth + DataWidth;

  localparam logic [ExpWidth-1:0]  ExpReset = ExpWidth'(2);
  localparam logic [MagWidth-1:0]  OneQ     = MagWidth'(1) << FracBits;
  localparam logic [MagWidth-1:0]  MagMax   = '1;
  localparam logic [ProdWidth:0]   HalfLsb  = (ProdWidth + 1)'(1) << (FracBits - 1);
  localparam logic [ProdWidth:0]   NegLimit = (ProdWidth + 1)'(1) << MagWidth;

  typedef enum logic {
    OpForward  = 1'b0,
    OpBackward = 1'b1
  } opcode_e;

  typedef enum logic {
    KindLoss     = 1'b0,
    KindGradient = 1'b1
  } kind_e;

  typedef struct packed {
    opcode_e                     opcode;
    logic signed [DataWidth-1:0] prediction;
    logic signed [DataWidth-1:0] target;
    logic signed [DataWidth-1:0] row_gradient;
    logic                        last_in_row;
  } in_item_t;

  typedef struct packed {
    kind_e                      kind;
    logic signed [AccWidth-1:0] value;
    logic                       saturated;
  } out_item_t;

  // classified work item between front and back
  typedef struct packed {
    opcode_e               opcode;
    logic                  last;
    logic [ExpWidth-1:0]   p;     // clamped exponent
    logic [DataWidth-1:0]  ad;    // |prediction - target|
    logic [DataWidth-1:0]  arg;   // |row_gradient|
    logic                  neg;   // gradient sign
  } cmd_t;

endpackage

`default_nettype wire

[sv/lplg_front.sv]
`default_nettype none

module lplg_front (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic [lplg_pkg::ExpWidth-1:0]      exponent_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  lplg_pkg::in_item_t                 in_data_i,
  output logic                               cmd_valid_o,
  input  logic                               cmd_ready_i,
  output lplg_pkg::cmd_t                     cmd_o
);

  localparam int DW = lplg_pkg::DataWidth;

  logic [DW:0]    diff;
  logic [DW:0]    diff_abs;
  logic [DW-1:0]  rg_abs;
  lplg_pkg::cmd_t cmd_d, cmd_q;
  logic           vld_q;

  always_comb begin
    diff     = {in_data_i.prediction[DW-1], in_data_i.prediction}
             - {in_data_i.target[DW-1], in_data_i.target};
    diff_abs = diff[DW] ? (~diff + 1'b1) : diff;
    rg_abs   = in_data_i.row_gradient[DW-1] ? (~in_data_i.row_gradient + 1'b1)
                                            : in_data_i.row_gradient;

    cmd_d.opcode = in_data_i.opcode;
    cmd_d.last   = in_data_i.last_in_row;
    cmd_d.ad     = diff_abs[DW-1:0];
    cmd_d.arg    = rg_abs;
    cmd_d.neg    = diff[DW] ^ in_data_i.row_gradient[DW-1];
    if (int'(exponent_i) > lplg_pkg::MaxExponent) begin
      cmd_d.p = lplg_pkg::ExpWidth'(lplg_pkg::MaxExponent);
    end else begin
      cmd_d.p = exponent_i;
    end
  end

  assign in_ready_o  = !vld_q || cmd_ready_i;
  assign cmd_valid_o = vld_q;
  assign cmd_o       = cmd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      vld_q <= 1'b1;
    end else if (cmd_ready_i) begin
      vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      cmd_q <= cmd_d;
    end
  end

endmodule

`default_nettype wire

[sv/lplg_fifo.sv]
`default_nettype none

module lplg_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_valid_i,
  output logic           push_ready_o,
  input  lplg_pkg::cmd_t push_data_i,
  output logic           pop_valid_o,
  input  logic           pop_ready_i,
  output lplg_pkg::cmd_t pop_data_o
);

  localparam int Depth    = lplg_pkg::QueueDepth;
  localparam int PtrWidth = $clog2(Depth);
  localparam int CntWidth = $clog2(Depth + 1);

  lplg_pkg::cmd_t      mem_q [Depth];
  logic [PtrWidth-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntWidth-1:0] cnt_q;
  logic                push, pop;

  assign push_ready_o = cnt_q != CntWidth'(Depth);
  assign pop_valid_o  = cnt_q != '0;
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PtrWidth'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrWidth'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

[sv/lplg_back.sv]
`default_nettype none

module lplg_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cmd_valid_i,
  output logic                cmd_ready_o,
  input  lplg_pkg::cmd_t      cmd_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output lplg_pkg::out_item_t out_data_o
);

  localparam int MW = lplg_pkg::MagWidth;
  localparam int PW = lplg_pkg::ProdWidth;
  localparam int AW = lplg_pkg::AccWidth;
  localparam int EW = lplg_pkg::ExpWidth;
  localparam int DW = lplg_pkg::DataWidth;

  typedef enum logic [5:0] {
    SIdle  = 6'b000001,
    SPow   = 6'b000010,
    SScale = 6'b000100,
    SGrad  = 6'b001000,
    SAcc   = 6'b010000,
    SOut   = 6'b100000
  } state_e;

  state_e              state_q, state_d;
  logic [EW-1:0]       cnt_q, cnt_d;
  logic [MW-1:0]       r_q, r_d;
  logic                sat_q, sat_d;
  logic [MW-1:0]       acc_q, acc_d;
  logic                row_sat_q, row_sat_d;
  lplg_pkg::cmd_t      wrk_q, wrk_d;
  lplg_pkg::out_item_t res_q, res_d;
  lplg_pkg::out_item_t out_q, out_d;
  logic                out_vld_q, out_vld_d;

  logic [DW-1:0] mul_b;
  logic [PW-1:0] prod;
  logic [PW:0]   rnd_ofs;
  logic [PW:0]   shr;
  logic          pow_over;
  logic [MW-1:0] pow_val;
  logic          scale_over;
  logic          grad_over;
  logic [AW-1:0] grad_mag;
  logic [AW-1:0] grad_val;
  logic [AW-1:0] acc_sum;
  logic [MW-1:0] new_acc;
  logic          new_sat;
  logic          out_free;
  logic [EW-1:0] n;

  // shared multiplier: power steps, scale by p, scale by row gradient
  always_comb begin
    unique case (state_q)
      SPow:    mul_b = wrk_q.ad;
      SScale:  mul_b = DW'(wrk_q.p);
      default: mul_b = wrk_q.arg;
    endcase
    prod    = PW'(r_q) * PW'(mul_b);
    rnd_ofs = (state_q == SGrad && wrk_q.neg) ? lplg_pkg::HalfLsb - 1'b1
                                              : lplg_pkg::HalfLsb;
    shr     = ({1'b0, prod} + rnd_ofs) >> lplg_pkg::FracBits;

    pow_over   = |shr[PW:MW];
    pow_val    = pow_over ? lplg_pkg::MagMax : shr[MW-1:0];
    scale_over = |prod[PW-1:MW];

    grad_over = wrk_q.neg ? (shr > lplg_pkg::NegLimit) : pow_over;
    if (grad_over) begin
      grad_mag = wrk_q.neg ? lplg_pkg::NegLimit[AW-1:0] : {1'b0, lplg_pkg::MagMax};
    end else begin
      grad_mag = shr[AW-1:0];
    end
    grad_val = wrk_q.neg ? (AW'(0) - grad_mag) : grad_mag;

    acc_sum = {1'b0, acc_q} + {1'b0, r_q};
    new_acc = acc_sum[AW-1] ? lplg_pkg::MagMax : acc_sum[MW-1:0];
    new_sat = row_sat_q | sat_q | acc_sum[AW-1];
  end

  assign out_free    = !out_vld_q || out_ready_i;
  assign cmd_ready_o = state_q == SIdle;
  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    r_d       = r_q;
    sat_d     = sat_q;
    acc_d     = acc_q;
    row_sat_d = row_sat_q;
    wrk_d     = wrk_q;
    res_d     = res_q;
    out_d     = out_q;
    out_vld_d = out_vld_q;
    n         = (cmd_i.opcode == lplg_pkg::OpBackward) ? cmd_i.p - 1'b1 : cmd_i.p;

    if (out_vld_q && out_ready_i) begin
      out_vld_d = 1'b0;
    end

    unique case (state_q)
      SIdle: begin
        if (cmd_valid_i) begin
          wrk_d = cmd_i;
          sat_d = 1'b0;
          if (cmd_i.opcode == lplg_pkg::OpBackward && cmd_i.p == '0) begin
            res_d.kind      = lplg_pkg::KindGradient;
            res_d.value     = '0;
            res_d.saturated = 1'b0;
            state_d         = SOut;
          end else begin
            r_d   = (n == '0) ? lplg_pkg::OneQ : MW'(cmd_i.ad);
            cnt_d = n - 1'b1;
            if (n >= EW'(2)) begin
              state_d = SPow;
            end else if (cmd_i.opcode == lplg_pkg::OpBackward) begin
              state_d = SScale;
            end else begin
              state_d = SAcc;
            end
          end
        end
      end
      SPow: begin
        r_d   = pow_val;
        sat_d = sat_q | pow_over;
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == EW'(1)) begin
          state_d = (wrk_q.opcode == lplg_pkg::OpBackward) ? SScale : SAcc;
        end
      end
      SScale: begin
        r_d     = scale_over ? lplg_pkg::MagMax : prod[MW-1:0];
        sat_d   = sat_q | scale_over;
        state_d = SGrad;
      end
      SGrad: begin
        res_d.kind      = lplg_pkg::KindGradient;
        res_d.value     = grad_val;
        res_d.saturated = sat_q | grad_over;
        state_d         = SOut;
      end
      SAcc: begin
        if (wrk_q.last) begin
          res_d.kind      = lplg_pkg::KindLoss;
          res_d.value     = {1'b0, new_acc};
          res_d.saturated = new_sat;
          acc_d           = '0;
          row_sat_d       = 1'b0;
          state_d         = SOut;
        end else begin
          acc_d     = new_acc;
          row_sat_d = new_sat;
          state_d   = SIdle;
        end
      end
      SOut: begin
        if (out_free) begin
          out_d     = res_q;
          out_vld_d = 1'b1;
          state_d   = SIdle;
        end
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= SIdle;
      cnt_q     <= '0;
      acc_q     <= '0;
      row_sat_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      acc_q     <= acc_d;
      row_sat_q <= row_sat_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    r_q   <= r_d;
    sat_q <= sat_d;
    wrk_q <= wrk_d;
    res_q <= res_d;
    out_q <= out_d;
  end

  a_out_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SOut && out_free) |=> out_vld_q)
    else $error("finished result not loaded into output register");

  a_row_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SAcc && wrk_q.last) |=> (acc_q == '0 && !row_sat_q))
    else $error("row accumulator not cleared after row loss");

  a_pow_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SPow) |-> (cnt_q != '0))
    else $error("power step with exhausted counter");

  a_zero_grad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SIdle && cmd_valid_i && cmd_i.opcode == lplg_pkg::OpBackward &&
     cmd_i.p == '0) |=> (state_q == SOut && res_q.value == '0 && !res_q.saturated))
    else $error("zero-exponent gradient not zero");

endmodule

`default_nettype wire

[sv/lp_loss_and_gradient.sv]
`default_nettype none

// Channel   Dir  Handshake              Payload
// in        in   in_valid_i/in_ready_o  in_data_i   (opcode, prediction, target,
//                                                    row_gradient, last_in_row)
// out       out  out_valid_o/out_ready_i out_data_o (kind, value, saturated)
// cfg       in   cfg_valid_i/cfg_ready_o cfg_data_i (exponent, 4 bits)
//
// Back end: one shared multiplier, one multiply per cycle while it works an item;
//   it takes a new item only when idle. Forward item: p-1 power steps for p >= 1,
//   none for p = 0, then accumulation, and an output step if it closes a row.
//   Backward item: p-2 power steps for p >= 2, none for p <= 1, then scale by p,
//   scale by row gradient and output; p = 0 goes straight to output with zero.
// The front register and a two-entry queue lie ahead of the back end.
// Reset: exponent returns to 2; row accumulator and its flag clear.
// Stalls: the queue decouples input from the back end; a result waiting in
//   the output register holds the back end only when a new result is ready.

module lp_loss_and_gradient (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  lplg_pkg::in_item_t            in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output lplg_pkg::out_item_t           out_data_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [lplg_pkg::ExpWidth-1:0] cfg_data_i
);

  // exponent register; the front samples it with each input transfer
  logic [lplg_pkg::ExpWidth-1:0] exp_q;

  // front register -> queue
  logic           fq_valid, fq_ready;
  lplg_pkg::cmd_t fq_cmd;

  // queue -> back end
  logic           qb_valid, qb_ready;
  lplg_pkg::cmd_t qb_cmd;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_q <= lplg_pkg::ExpReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      exp_q <= cfg_data_i;
    end
  end

  // front: difference, magnitudes, sign and exponent clamp per transfer
  lplg_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .exponent_i  (exp_q),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .cmd_valid_o (fq_valid),
    .cmd_ready_i (fq_ready),
    .cmd_o       (fq_cmd)
  );

  // short queue so the front keeps taking transfers while the back end works
  lplg_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fq_valid),
    .push_ready_o (fq_ready),
    .push_data_i  (fq_cmd),
    .pop_valid_o  (qb_valid),
    .pop_ready_i  (qb_ready),
    .pop_data_o   (qb_cmd)
  );

  // back end: power loop, scaling, row accumulation, output register
  lplg_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (qb_valid),
    .cmd_ready_o (qb_ready),
    .cmd_i       (qb_cmd),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire
